>>> src/radix_digit_formatter_top_assert.svh
// Assertion macros for the radix digit formatter.
// Used by radix_digit_formatter_top.sv; needs a clock aclk and reset aresetn in scope.
`ifndef RADIX_DIGIT_FORMATTER_TOP_ASSERT_SVH
`define RADIX_DIGIT_FORMATTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define RDF_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("rdf assertion failed");
// Checked in every cycle, reset included.
`define RDF_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("rdf assertion failed");
`else
`define RDF_ASSERT(label, prop)
`define RDF_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> src/rdf_pkg.sv
// Package for the radix digit formatter: payload structs, radix codes, work command.
// No dependencies.
package rdf_pkg;

    localparam int VALUE_BITS = 64;

    // Work word is left-aligned so the top digit always sits at the MSB end.
    localparam int SH_W       = VALUE_BITS + 3;
    localparam int BIN_DIGITS = VALUE_BITS;
    localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int OCT_PAD    = 3 * OCT_DIGITS - VALUE_BITS;
    localparam int HEX_PAD    = 4 * HEX_DIGITS - VALUE_BITS;
    localparam int CNT_W      = $clog2(VALUE_BITS);

    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_RUN
    } back_state_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  radix_mode;
        logic        upper_case;
    } in_t;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       is_last;
    } out_t;

    // One classified item handed from front to back.
    typedef struct packed {
        logic [SH_W-1:0]  word;
        radix_t           radix;
        logic             upper;
        logic [CNT_W-1:0] last_idx;  // digit count minus one
    } cmd_t;

    function automatic logic [6:0] digit_ascii(input logic [3:0] d, input logic upper);
        logic [6:0] base;
        base = upper ? 7'd65 : 7'd97;
        if (d < 4'd10) begin
            digit_ascii = 7'd48 + {3'b000, d};
        end else begin
            digit_ascii = base + {3'b000, d} - 7'd10;
        end
    endfunction

endpackage

>>> src/rdf_front.sv
// Front end: accepts input transfers, decodes the radix and aligns the value.
// Depends on rdf_pkg.
module rdf_front import rdf_pkg::*; (
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    input  logic q_full,
    output logic q_push,
    output cmd_t q_cmd
);

    logic [VALUE_BITS-1:0] val;
    logic [SH_W-1:0]       raw;

    assign val     = s_data.value[VALUE_BITS-1:0];
    assign raw     = {val, 3'b000};
    assign s_ready = aresetn && !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_cmd.upper = s_data.upper_case;
        case (s_data.radix_mode)
            RADIX_BIN: begin
                q_cmd.radix    = RADIX_BIN;
                q_cmd.word     = raw;
                q_cmd.last_idx = CNT_W'(BIN_DIGITS - 1);
            end
            RADIX_OCT: begin
                q_cmd.radix    = RADIX_OCT;
                q_cmd.word     = raw >> OCT_PAD;
                q_cmd.last_idx = CNT_W'(OCT_DIGITS - 1);
            end
            default: begin
                // mode three is handled as hex
                q_cmd.radix    = RADIX_HEX;
                q_cmd.word     = raw >> HEX_PAD;
                q_cmd.last_idx = CNT_W'(HEX_DIGITS - 1);
            end
        endcase
    end

endmodule

>>> src/rdf_fifo.sv
// Two-entry command queue between front and back.
// Depends on rdf_pkg.
module rdf_fifo import rdf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_cmd
);

    cmd_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_cmd   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> src/rdf_back.sv
// Back end: walks digits MSB first, drops leading zeros, drives the output register.
// Depends on rdf_pkg.
module rdf_back import rdf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    input  cmd_t q_cmd,
    output logic q_pop,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    back_state_t      state_reg, state_next;
    logic [SH_W-1:0]  sh_reg, sh_next;
    radix_t           radix_reg, radix_next;
    logic             upper_reg, upper_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             started_reg, started_next;
    logic             valid_reg, valid_next;
    out_t             data_reg, data_next;

    logic       out_free;
    logic       advance;
    logic       last;
    logic       emit;
    logic [3:0] digit;

    assign out_free = !valid_reg || m_ready;
    assign advance  = (state_reg == BACK_RUN) && out_free;
    assign last     = (cnt_reg == '0);
    assign emit     = (digit != 4'd0) || started_reg || last;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_comb begin
        case (radix_reg)
            RADIX_BIN: digit = {3'b000, sh_reg[SH_W-1]};
            RADIX_OCT: digit = {1'b0, sh_reg[SH_W-1 -: 3]};
            default:   digit = sh_reg[SH_W-1 -: 4];
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        sh_next      = sh_reg;
        radix_next   = radix_reg;
        upper_next   = upper_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        valid_next   = valid_reg && !m_ready;
        data_next    = data_reg;
        q_pop        = 1'b0;

        if (advance) begin
            case (radix_reg)
                RADIX_BIN: sh_next = sh_reg << 1;
                RADIX_OCT: sh_next = sh_reg << 3;
                default:   sh_next = sh_reg << 4;
            endcase
            cnt_next     = cnt_reg - CNT_W'(1);
            started_next = started_reg || emit;
            if (emit) begin
                valid_next           = 1'b1;
                data_next.digit_char = digit_ascii(digit, upper_reg);
                data_next.is_last    = last;
            end
            if (last) begin
                state_next = BACK_IDLE;
            end
        end

        // next item loads as soon as the current one hands over its final digit
        if ((state_reg == BACK_IDLE || (advance && last)) && q_valid) begin
            q_pop        = 1'b1;
            state_next   = BACK_RUN;
            sh_next      = q_cmd.word;
            radix_next   = q_cmd.radix;
            upper_next   = q_cmd.upper;
            cnt_next     = q_cmd.last_idx;
            started_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BACK_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg      <= sh_next;
        radix_reg   <= radix_next;
        upper_reg   <= upper_next;
        cnt_reg     <= cnt_next;
        started_reg <= started_next;
        data_reg    <= data_next;
    end

endmodule

>>> src/radix_digit_formatter_top.sv
// Channel  Ports                      Payload
// input    s_valid s_ready s_data     in_t: value, radix_mode, upper_case
// output   m_valid m_ready m_data     out_t: digit_char, is_last (one digit per transfer)
//
// The digit sequencer takes one digit position of the radix per cycle while the output
// is not stalled, leading zeros included (64 in binary, 22 in octal, 16 in hex at VALUE_BITS = 64).
// The next item starts in the cycle after the final digit of the previous one.
// A two-entry queue lets the input side keep taking transfers while digits drain.
// A stalled output holds the sequencer; synchronous active-low reset clears control only.
// Depends on rdf_pkg, rdf_front, rdf_fifo, rdf_back and the assertion header.
`include "radix_digit_formatter_top_assert.svh"

module radix_digit_formatter_top import rdf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    // ASCII digit 0-9, A-F or a-f
    function automatic logic is_digit_char(input logic [6:0] c);
        is_digit_char = (c >= 7'd48 && c <= 7'd57) || (c >= 7'd65 && c <= 7'd70)
                        || (c >= 7'd97 && c <= 7'd102);
    endfunction

    rdf_front u_front (
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    rdf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cmd   (pop_cmd)
    );

    rdf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (pop_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `RDF_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid)
    `RDF_ASSERT(a_no_push_when_full, q_push |-> !q_full)
    `RDF_ASSERT(a_no_pop_when_empty, q_pop |-> q_valid)
    `RDF_ASSERT(a_digit_range, m_valid |-> is_digit_char(m_data.digit_char))

endmodule
